// File: design/udlp_pkg.sv
// ----------------------------------------------------------------------------
// udlp_pkg
// Shared types, codes and byte classes for the dependency list parser.
// ----------------------------------------------------------------------------
package udlp_pkg;

	// default size limits
	localparam int DEF_MAX_TEXT_BYTES = 4096;
	localparam int DEF_MAX_NAME_BYTES = 64;
	localparam int DEF_MAX_ENTRIES    = 256;

	// fixed field widths of a result word
	localparam int NAME_OFF_W = 12;
	localparam int NAME_LEN_W = 7;
	localparam int ENTRY_NUM_W = 8;

	// parse phases
	localparam logic [3:0] PH_IDLE       = 4'd0;
	localparam logic [3:0] PH_OPEN       = 4'd1;
	localparam logic [3:0] PH_ENTRY      = 4'd2;
	localparam logic [3:0] PH_NAME_FIRST = 4'd3;
	localparam logic [3:0] PH_NAME       = 4'd4;
	localparam logic [3:0] PH_DEF_SIGN   = 4'd5;
	localparam logic [3:0] PH_DEF_CLOSE  = 4'd6;
	localparam logic [3:0] PH_AFTER_DEF  = 4'd7;
	localparam logic [3:0] PH_AFTER_COND = 4'd8;

	// result codes
	localparam logic [1:0] PFX_NONE  = 2'd0;
	localparam logic [1:0] PFX_BANG  = 2'd1;
	localparam logic [1:0] PFX_DASH  = 2'd2;
	localparam logic [1:0] DFL_NONE  = 2'd0;
	localparam logic [1:0] DFL_PLUS  = 2'd1;
	localparam logic [1:0] DFL_MINUS = 2'd2;
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_SYNTAX = 2'd1;
	localparam logic [1:0] ST_SIZE   = 2'd2;

	// bytes of interest
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_QUEST  = 8'h3F;

	typedef struct packed {
		logic                   entry_valid;
		logic [1:0]             prefix_code;
		logic [1:0]             default_code;
		logic                   conditional;
		logic [NAME_OFF_W-1:0]  name_offset;
		logic [NAME_LEN_W-1:0]  name_length;
		logic [ENTRY_NUM_W-1:0] entry_number;
		logic                   list_done;
		logic [1:0]             status;
	} udlp_res_t;

	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic is_name_byte(input logic [7:0] c);
		return is_alnum(c) || c == CH_PLUS || c == CH_UNDER || c == CH_AT ||
			c == CH_DASH;
	endfunction

endpackage

// File: design/use_dependency_list_parser_core.sv
// A byte is taken into the input register; its result, if any, is then loaded
// into the result register, which presents it on the output channel.
// One byte per cycle unless a result waits on a full result register, set by
// the combinational parse step between the input register and the result register.
// Reset (arst_n low, asynchronous): parser idle, counters zero, both stages empty.
// ----------------------------------------------------------------------------
// use_dependency_list_parser_core
// Streaming parser for bracketed flag-dependency lists, one byte per word.
// ----------------------------------------------------------------------------
module use_dependency_list_parser_core import udlp_pkg::*; #(
	parameter int MAX_TEXT_BYTES = DEF_MAX_TEXT_BYTES,
	parameter int MAX_NAME_BYTES = DEF_MAX_NAME_BYTES,
	parameter int MAX_ENTRIES    = DEF_MAX_ENTRIES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  logic [7:0]             ch,
	input  logic                   start_req,
	output logic                   res_valid,
	input  logic                   res_ready,
	output logic                   entry_valid,
	output logic [1:0]             prefix_code,
	output logic [1:0]             default_code,
	output logic                   conditional,
	output logic [NAME_OFF_W-1:0]  name_offset,
	output logic [NAME_LEN_W-1:0]  name_length,
	output logic [ENTRY_NUM_W-1:0] entry_number,
	output logic                   list_done,
	output logic [1:0]             status
);

	logic       vld_s1;
	logic [7:0] ch_s1;
	logic       start_s1;
	logic       adv;
	logic       has_res;
	logic       free;
	udlp_res_t  res_d, res_q;

	// a byte with no result never waits on the output side
	assign adv        = vld_s1 && (free || !has_res);
	assign item_ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item_ready) begin
			vld_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			ch_s1    <= ch;
			start_s1 <= start_req;
		end
	end

	udlp_parse #(
		.MAX_TEXT_BYTES(MAX_TEXT_BYTES),
		.MAX_NAME_BYTES(MAX_NAME_BYTES),
		.MAX_ENTRIES   (MAX_ENTRIES)
	) parse_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.ch       (ch_s1),
		.start_req(start_s1),
		.has_res  (has_res),
		.res      (res_d)
	);

	udlp_obuf obuf_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv && has_res),
		.d        (res_d),
		.free     (free),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.q        (res_q)
	);

	assign entry_valid  = res_q.entry_valid;
	assign prefix_code  = res_q.prefix_code;
	assign default_code = res_q.default_code;
	assign conditional  = res_q.conditional;
	assign name_offset  = res_q.name_offset;
	assign name_length  = res_q.name_length;
	assign entry_number = res_q.entry_number;
	assign list_done    = res_q.list_done;
	assign status       = res_q.status;

endmodule

// File: design/udlp_parse.sv
// ----------------------------------------------------------------------------
// udlp_parse
// Parse state machine and counters; decides one byte per enabled cycle.
// ----------------------------------------------------------------------------
module udlp_parse import udlp_pkg::*; #(
	parameter int MAX_TEXT_BYTES = DEF_MAX_TEXT_BYTES,
	parameter int MAX_NAME_BYTES = DEF_MAX_NAME_BYTES,
	parameter int MAX_ENTRIES    = DEF_MAX_ENTRIES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] ch,
	input  logic       start_req,
	output logic       has_res,
	output udlp_res_t  res
);

	localparam int PW = $clog2(MAX_TEXT_BYTES + 1);
	localparam int LW = $clog2(MAX_NAME_BYTES + 1);
	localparam int EW = $clog2(MAX_ENTRIES + 1);

	logic [3:0]    phase_q, phase_d;
	logic [PW-1:0] pos_q, pos_d;
	logic [PW-1:0] off_q, off_d;
	logic [LW-1:0] len_q, len_d;
	logic [EW-1:0] ent_q, ent_d;
	logic [1:0]    pfx_q, pfx_d;
	logic [1:0]    dfl_q, dfl_d;
	logic          cond_q, cond_d;

	logic       err, emit, last;
	logic [1:0] err_code;

	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		off_d    = off_q;
		len_d    = len_q;
		ent_d    = ent_q;
		pfx_d    = pfx_q;
		dfl_d    = dfl_q;
		cond_d   = cond_q;
		res      = '0;
		has_res  = 1'b0;
		err      = 1'b0;
		err_code = ST_SYNTAX;
		emit     = 1'b0;
		last     = 1'b0;

		if (start_req) begin
			pos_d  = PW'(1);
			ent_d  = '0;
			off_d  = '0;
			len_d  = '0;
			pfx_d  = PFX_NONE;
			dfl_d  = DFL_NONE;
			cond_d = 1'b0;
			if (ch != CH_LBRACK) begin
				err = 1'b1;
			end else begin
				phase_d = PH_OPEN;
			end
		end else if (phase_q != PH_IDLE) begin
			if (pos_q >= PW'(MAX_TEXT_BYTES)) begin
				err      = 1'b1;
				err_code = ST_SIZE;
			end else begin
				pos_d = pos_q + PW'(1);
				if (ch == CH_NUL) begin
					err = 1'b1;
				end else begin
					unique case (phase_q) inside
						PH_OPEN, PH_ENTRY: begin
							if (ch == CH_RBRACK) begin
								if (phase_q == PH_ENTRY) begin
									err = 1'b1;
								end else begin
									has_res       = 1'b1;
									res.list_done = 1'b1;
									phase_d       = PH_IDLE;
								end
							end else if (ch == CH_BANG || ch == CH_DASH) begin
								pfx_d   = (ch == CH_BANG) ? PFX_BANG : PFX_DASH;
								phase_d = PH_NAME_FIRST;
							end else if (is_alnum(ch)) begin
								off_d   = pos_q;
								len_d   = LW'(1);
								phase_d = PH_NAME;
							end else begin
								err = 1'b1;
							end
						end
						PH_NAME_FIRST: begin
							if (is_alnum(ch)) begin
								off_d   = pos_q;
								len_d   = LW'(1);
								phase_d = PH_NAME;
							end else begin
								err = 1'b1;
							end
						end
						PH_NAME: begin
							if (ch == CH_COMMA || ch == CH_RBRACK) begin
								emit = 1'b1;
								last = (ch == CH_RBRACK);
							end else if (ch == CH_LPAREN) begin
								phase_d = PH_DEF_SIGN;
							end else if (ch == CH_QUEST) begin
								cond_d  = 1'b1;
								phase_d = PH_AFTER_COND;
							end else if (is_name_byte(ch)) begin
								if (len_q >= LW'(MAX_NAME_BYTES)) begin
									err      = 1'b1;
									err_code = ST_SIZE;
								end else begin
									len_d = len_q + LW'(1);
								end
							end else begin
								err = 1'b1;
							end
						end
						PH_DEF_SIGN: begin
							if (ch == CH_PLUS || ch == CH_DASH) begin
								dfl_d   = (ch == CH_PLUS) ? DFL_PLUS : DFL_MINUS;
								phase_d = PH_DEF_CLOSE;
							end else begin
								err = 1'b1;
							end
						end
						PH_DEF_CLOSE: begin
							if (ch == CH_RPAREN) begin
								phase_d = PH_AFTER_DEF;
							end else begin
								err = 1'b1;
							end
						end
						PH_AFTER_DEF: begin
							if (ch == CH_QUEST) begin
								cond_d  = 1'b1;
								phase_d = PH_AFTER_COND;
							end else if (ch == CH_COMMA || ch == CH_RBRACK) begin
								emit = 1'b1;
								last = (ch == CH_RBRACK);
							end else begin
								err = 1'b1;
							end
						end
						PH_AFTER_COND: begin
							if (ch == CH_COMMA || ch == CH_RBRACK) begin
								emit = 1'b1;
								last = (ch == CH_RBRACK);
							end else begin
								err = 1'b1;
							end
						end
						default: begin
							err = 1'b1;
						end
					endcase
				end
			end
		end

		if (emit) begin
			if (ent_q >= EW'(MAX_ENTRIES)) begin
				err      = 1'b1;
				err_code = ST_SIZE;
			end else begin
				has_res          = 1'b1;
				res.entry_valid  = 1'b1;
				res.prefix_code  = pfx_q;
				res.default_code = dfl_q;
				res.conditional  = cond_q;
				res.name_offset  = NAME_OFF_W'(off_q);
				res.name_length  = NAME_LEN_W'(len_q);
				res.entry_number = ENTRY_NUM_W'(ent_q);
				res.list_done    = last;
				ent_d            = ent_q + EW'(1);
				off_d            = '0;
				len_d            = '0;
				pfx_d            = PFX_NONE;
				dfl_d            = DFL_NONE;
				cond_d           = 1'b0;
				phase_d          = last ? PH_IDLE : PH_ENTRY;
			end
		end

		// any error ends the list with a bare status word
		if (err) begin
			res           = '0;
			res.list_done = 1'b1;
			res.status    = err_code;
			has_res       = 1'b1;
			phase_d       = PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= '0;
			off_q   <= '0;
			len_q   <= '0;
			ent_q   <= '0;
			pfx_q   <= PFX_NONE;
			dfl_q   <= DFL_NONE;
			cond_q  <= 1'b0;
		end else if (en) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			off_q   <= off_d;
			len_q   <= len_d;
			ent_q   <= ent_d;
			pfx_q   <= pfx_d;
			dfl_q   <= dfl_d;
			cond_q  <= cond_d;
		end
	end

endmodule

// File: design/udlp_obuf.sv
// ----------------------------------------------------------------------------
// udlp_obuf
// Result register on the output channel.
// ----------------------------------------------------------------------------
module udlp_obuf import udlp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  udlp_res_t d,
	output logic      free,
	output logic      res_valid,
	input  logic      res_ready,
	output udlp_res_t q
);

	logic      vld_q;
	udlp_res_t data_q;

	// register can take a new word if empty or being drained this cycle
	assign free      = !vld_q || res_ready;
	assign res_valid = vld_q;
	assign q         = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (res_ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= d;
		end
	end

endmodule

// File: design/udlp_chk.sv
// ----------------------------------------------------------------------------
// udlp_chk
// Port-level checks on the parser's result channel.
// ----------------------------------------------------------------------------
module udlp_chk import udlp_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   res_valid,
	input logic                   res_ready,
	input logic                   entry_valid,
	input logic [1:0]             status,
	input logic [NAME_LEN_W-1:0]  name_length,
	input logic [ENTRY_NUM_W-1:0] entry_number,
	input logic                   list_done
);

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(status) &&
		$stable(entry_valid) && $stable(list_done))
		else $error("result word changed while stalled");

	// errors always close the list and carry no entry
	a_err_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status != ST_OK |-> list_done && !entry_valid)
		else $error("error word without list end");

	// a word without an entry only ever ends a list, with cleared fields
	a_bare_word: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !entry_valid |-> list_done && name_length == '0 &&
		entry_number == '0)
		else $error("bare word not a clean list end");

	// an emitted entry always has a non-empty name
	a_name_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && entry_valid |-> name_length != '0 && status == ST_OK)
		else $error("entry with empty name or bad status");

endmodule

bind use_dependency_list_parser_core udlp_chk chk_i (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res_valid),
	.res_ready   (res_ready),
	.entry_valid (entry_valid),
	.status      (status),
	.name_length (name_length),
	.entry_number(entry_number),
	.list_done   (list_done)
);
